>>> rtl/mrbm_pkg.sv
// Shared types and constants for the maximal rectangle unit.
package mrbm_pkg;

    localparam int AREA_W    = 17;
    localparam int ROW_LEN_W = 9;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    localparam logic [AREA_W-1:0]    AREA_MAX      = 17'h1FFFF;
    localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = 9'd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_LFETCH,
        ST_LPOP,
        ST_RFETCH,
        ST_RPOP,
        ST_DRAIN,
        ST_EMIT
    } mrbm_state_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } stk_ctl_t;

endpackage

>>> rtl/mrbm_stack.sv
// Monotonic stack of (height, column) entries with cached top and next entry.
module mrbm_stack
    import mrbm_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int HW    = 9,
    parameter int CW    = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  stk_ctl_t      ctl,
    input  logic [HW-1:0] push_h,
    input  logic [CW-1:0] push_idx,
    output logic          empty,
    output logic [HW-1:0] top_h,
    output logic [CW-1:0] top_idx
);

    localparam int LW = $clog2(DEPTH + 1);
    localparam int EW = HW + CW;

    logic [EW-1:0] stack_mem [DEPTH];
    logic [LW-1:0] sp_reg;
    logic [LW-1:0] sp_next;
    logic [LW-1:0] rd_addr_full;
    logic [EW-1:0] top_reg;
    logic [EW-1:0] below_reg;

    always_comb
    begin
        if (ctl.clear)
        begin
            sp_next = '0;
        end
        else if (ctl.push)
        begin
            sp_next = sp_reg + LW'(1);
        end
        else if (ctl.pop)
        begin
            sp_next = sp_reg - LW'(1);
        end
        else
        begin
            sp_next = sp_reg;
        end
    end

    // The read port always fetches the entry just below the next top.
    assign rd_addr_full = sp_next - LW'(2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            stack_mem[sp_reg[CW-1:0]] <= {push_h, push_idx};
        end
        below_reg <= stack_mem[rd_addr_full[CW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            top_reg <= {push_h, push_idx};
        end
        else if (ctl.pop)
        begin
            top_reg <= below_reg;
        end
    end

    assign empty   = (sp_reg == '0);
    assign top_h   = top_reg[EW-1:CW];
    assign top_idx = top_reg[CW-1:0];

`ifndef SYNTHESIS
    property p_no_push_and_pop;
        @(posedge clk) disable iff (!rst_n) !(ctl.push && ctl.pop);
    endproperty
    a_no_push_and_pop: assert property (p_no_push_and_pop)
        else $error("stack push and pop in the same cycle");

    property p_no_pop_empty;
        @(posedge clk) disable iff (!rst_n) (ctl.pop && !ctl.clear) |-> (sp_reg != '0);
    endproperty
    a_no_pop_empty: assert property (p_no_pop_empty)
        else $error("stack popped while empty");

    property p_depth;
        @(posedge clk) disable iff (!rst_n) (32'(sp_reg) <= DEPTH);
    endproperty
    a_depth: assert property (p_depth)
        else $error("stack pointer beyond depth");
`endif

endmodule

>>> rtl/maximal_rectangle_binary_matrix_unit.sv
// Top level of the maximal all-ones rectangle unit for a streamed binary matrix.
// Pixels arrive one per transaction in row-major order; row_length sets the pixels per row.
// A pixel that does not close a row has its column height read and then written. A pixel that
// closes a row of w columns then runs a left and a right pass of the shared stack unit over
// the row, each column popping the entries it covers and pushing one entry; the sequencer
// accepts no new pixel until it has finished with the current one, which sets the rate of the
// unit. On the pixel with tlast the largest area is sent as one output transaction and the
// unit starts a new matrix. No clearing pass is run.
module maximal_rectangle_binary_matrix_unit
    import mrbm_pkg::*;
#(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [ROW_LEN_W-1:0]  cfg_data,      // row_length
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [0] pixel_set, upper bits zero
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // [16:0] area, upper bits zero
);

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int LW = $clog2(MAX_COLS + 1);
    localparam int HW = $clog2(MAX_ROWS + 1);
    localparam int PW = HW + LW;
    localparam int EW = (PW > AREA_W) ? PW : AREA_W;

    mrbm_state_t          state_reg;
    mrbm_state_t          state_next;
    logic [ROW_LEN_W-1:0] row_length_reg;
    logic [CW-1:0]        col_pos_reg;
    logic                 first_row_reg;
    logic [AREA_W-1:0]    best_reg;
    logic                 set_reg;
    logic                 last_reg;
    logic                 close_reg;
    logic [CW-1:0]        pix_col_reg;
    logic [LW-1:0]        width_reg;
    logic [CW-1:0]        col_reg;
    logic [CW-1:0]        col_next;
    logic [HW-1:0]        mul_h_reg;
    logic [LW-1:0]        mul_s_reg;
    logic                 mul_v_reg;
    logic [PW-1:0]        prod_reg;
    logic                 prod_v_reg;
    logic                 out_valid_reg;
    logic [AREA_W-1:0]    out_area_reg;

    logic [HW-1:0]        heights_mem [MAX_COLS];
    logic [CW-1:0]        left_mem    [MAX_COLS];
    logic [HW-1:0]        hd_rd_reg;
    logic [CW-1:0]        left_rd_reg;

    logic                 in_fire;
    logic                 emit;
    logic                 row_done;
    logic                 mul_load;
    logic [CW-1:0]        hd_addr;
    logic                 hd_we;
    logic [HW-1:0]        hd_wdata;
    logic                 left_we;
    logic [CW-1:0]        left_wdata;
    logic [LW-1:0]        len_eff;
    logic [CW-1:0]        pos_eff;
    logic                 pos_closes;
    logic [HW:0]          h_inc;
    logic                 pop_cond;
    logic [LW-1:0]        right_val;
    logic [LW-1:0]        span_val;
    logic [EW-1:0]        prod_ext;
    logic [AREA_W-1:0]    prod_sat;

    stk_ctl_t             stk_ctl;
    logic                 stk_empty;
    logic [HW-1:0]        stk_top_h;
    logic [CW-1:0]        stk_top_idx;

    mrbm_stack #(
        .DEPTH (MAX_COLS),
        .HW    (HW),
        .CW    (CW)
    ) u_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (stk_ctl),
        .push_h   (hd_rd_reg),
        .push_idx (col_reg),
        .empty    (stk_empty),
        .top_h    (stk_top_h),
        .top_idx  (stk_top_idx)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_area_reg);

    // Row length zero acts as one, above the column count as the column count.
    always_comb
    begin
        if (row_length_reg == '0)
        begin
            len_eff = LW'(1);
        end
        else if (32'(row_length_reg) > 32'(MAX_COLS))
        begin
            len_eff = LW'(MAX_COLS);
        end
        else
        begin
            len_eff = LW'(row_length_reg);
        end
        if (LW'(col_pos_reg) >= len_eff)
        begin
            pos_eff = CW'(len_eff - LW'(1));
        end
        else
        begin
            pos_eff = col_pos_reg;
        end
    end

    assign pos_closes = s_axis_tlast || ((LW'(pos_eff) + LW'(1)) == len_eff);

    assign h_inc = {1'b0, hd_rd_reg} + (HW + 1)'(1);

    always_comb
    begin
        if (first_row_reg)
        begin
            hd_wdata = HW'(set_reg);
        end
        else if (!set_reg)
        begin
            hd_wdata = '0;
        end
        else if (h_inc > (HW + 1)'(MAX_ROWS))
        begin
            hd_wdata = HW'(MAX_ROWS);
        end
        else
        begin
            hd_wdata = h_inc[HW-1:0];
        end
    end

    assign pop_cond   = !stk_empty && (stk_top_h >= hd_rd_reg);
    assign right_val  = stk_empty ? width_reg : LW'(stk_top_idx);
    assign span_val   = right_val - LW'(left_rd_reg);
    assign left_wdata = stk_empty ? '0 : (stk_top_idx + CW'(1));

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        hd_addr    = col_reg;
        hd_we      = 1'b0;
        left_we    = 1'b0;
        stk_ctl    = '0;
        mul_load   = 1'b0;
        row_done   = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                hd_addr = pos_eff;
                if (in_fire)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                hd_we = 1'b1;
                if (close_reg)
                begin
                    col_next      = '0;
                    stk_ctl.clear = 1'b1;
                    state_next    = ST_LFETCH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LFETCH:
            begin
                state_next = ST_LPOP;
            end
            ST_LPOP:
            begin
                if (pop_cond)
                begin
                    stk_ctl.pop = 1'b1;
                end
                else
                begin
                    left_we = 1'b1;
                    if ((LW'(col_reg) + LW'(1)) == width_reg)
                    begin
                        stk_ctl.clear = 1'b1;
                        col_next      = CW'(width_reg - LW'(1));
                        state_next    = ST_RFETCH;
                    end
                    else
                    begin
                        stk_ctl.push = 1'b1;
                        col_next     = col_reg + CW'(1);
                        hd_addr      = col_reg + CW'(1);
                    end
                end
            end
            ST_RFETCH:
            begin
                state_next = ST_RPOP;
            end
            ST_RPOP:
            begin
                if (pop_cond)
                begin
                    stk_ctl.pop = 1'b1;
                end
                else
                begin
                    mul_load = 1'b1;
                    if (col_reg == '0)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        stk_ctl.push = 1'b1;
                        col_next     = col_reg - CW'(1);
                        hd_addr      = col_reg - CW'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!mul_v_reg && !prod_v_reg)
                begin
                    row_done   = 1'b1;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hd_we)
        begin
            heights_mem[pix_col_reg] <= hd_wdata;
        end
        hd_rd_reg <= heights_mem[hd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (left_we)
        begin
            left_mem[col_reg] <= left_wdata;
        end
        left_rd_reg <= left_mem[hd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= ROW_LEN_RESET;
            col_pos_reg    <= '0;
            first_row_reg  <= 1'b1;
            best_reg       <= '0;
            mul_v_reg      <= 1'b0;
            prod_v_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                row_length_reg <= cfg_data;
            end
            if (state_reg == ST_LOAD && !close_reg)
            begin
                col_pos_reg <= pix_col_reg + CW'(1);
            end
            else if (row_done)
            begin
                col_pos_reg <= '0;
            end
            if (row_done)
            begin
                first_row_reg <= 1'b0;
            end
            else if (emit)
            begin
                first_row_reg <= 1'b1;
            end
            if (emit)
            begin
                best_reg <= '0;
            end
            else if (prod_v_reg && (prod_sat > best_reg))
            begin
                best_reg <= prod_sat;
            end
            mul_v_reg  <= mul_load;
            prod_v_reg <= mul_v_reg;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            set_reg     <= s_axis_tdata[0];
            last_reg    <= s_axis_tlast;
            close_reg   <= pos_closes;
            pix_col_reg <= pos_eff;
            width_reg   <= LW'(pos_eff) + LW'(1);
        end
        col_reg <= col_next;
        if (mul_load)
        begin
            mul_h_reg <= hd_rd_reg;
            mul_s_reg <= span_val;
        end
        prod_reg <= PW'(mul_h_reg) * PW'(mul_s_reg);
        if (emit)
        begin
            out_area_reg <= best_reg;
        end
    end

    assign prod_ext = EW'(prod_reg);
    assign prod_sat = (prod_ext > EW'(AREA_MAX)) ? AREA_MAX : prod_ext[AREA_W-1:0];

`ifndef SYNTHESIS
    property p_emit_after_drain;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == ST_EMIT) |-> (!mul_v_reg && !prod_v_reg);
    endproperty
    a_emit_after_drain: assert property (p_emit_after_drain)
        else $error("result sent while products are still in flight");

    property p_best_cleared;
        @(posedge clk) disable iff (!rst_n) emit |=> (best_reg == '0);
    endproperty
    a_best_cleared: assert property (p_best_cleared)
        else $error("best area not cleared after a matrix");

    property p_height_bound;
        @(posedge clk) disable iff (!rst_n) hd_we |-> (32'(hd_wdata) <= MAX_ROWS);
    endproperty
    a_height_bound: assert property (p_height_bound)
        else $error("column height above the row limit");

    property p_span_positive;
        @(posedge clk) disable iff (!rst_n)
            mul_load |-> (right_val > LW'(left_rd_reg));
    endproperty
    a_span_positive: assert property (p_span_positive)
        else $error("rectangle span is not positive");
`endif

endmodule
